// ===== design/base64_codec_core_macros.svh =====
// ----------------------------------------------------------------------------
// Base64 codec assertion macros
// Shared concurrent assertion forms used by the codec checker.
// ----------------------------------------------------------------------------
`ifndef BASE64_CODEC_CORE_MACROS_SVH
`define BASE64_CODEC_CORE_MACROS_SVH

// Overlapping implication, checked at every clock edge outside reset.
`define B64C_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define B64C_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/b64c_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 codec package
// Payload types, result kinds and alphabet mapping functions.
// ----------------------------------------------------------------------------
package b64c_pkg;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      out_kind;
        logic       out_last;
    } result_t;

    localparam logic [7:0] PAD_CHAR   = 8'h3d;
    localparam logic [7:0] PLUS_CHAR  = 8'h2b;
    localparam logic [7:0] SLASH_CHAR = 8'h2f;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5a;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7a;
    localparam logic [7:0] DIGIT_0    = 8'h30;
    localparam logic [7:0] DIGIT_9    = 8'h39;

    // Maps a 6-bit value to its character of the standard alphabet.
    function automatic logic [7:0] char_of(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
        begin
            c = UPPER_A + {2'b00, v};
        end
        else if (v < 6'd52)
        begin
            c = LOWER_A + {2'b00, v - 6'd26};
        end
        else if (v < 6'd62)
        begin
            c = DIGIT_0 + {2'b00, v - 6'd52};
        end
        else if (v == 6'd62)
        begin
            c = PLUS_CHAR;
        end
        else
        begin
            c = SLASH_CHAR;
        end
        return c;
    endfunction

    // Returns the 6-bit value of a character, with bit 6 set when it is not
    // part of the alphabet.
    function automatic logic [6:0] value_of(input logic [7:0] c);
        logic [6:0] v;
        if (c >= UPPER_A && c <= UPPER_Z)
        begin
            v = 7'(c - UPPER_A);
        end
        else if (c >= LOWER_A && c <= LOWER_Z)
        begin
            v = 7'(c - LOWER_A) + 7'd26;
        end
        else if (c >= DIGIT_0 && c <= DIGIT_9)
        begin
            v = 7'(c - DIGIT_0) + 7'd52;
        end
        else if (c == PLUS_CHAR)
        begin
            v = 7'd62;
        end
        else if (c == SLASH_CHAR)
        begin
            v = 7'd63;
        end
        else
        begin
            v = 7'd64;
        end
        return v;
    endfunction

endpackage

// ===== design/base64_codec_core.sv =====
// ----------------------------------------------------------------------------
// Base64 codec core
// Streaming standard-alphabet base64 encoder and decoder with a mode register.
// ----------------------------------------------------------------------------
// Items enter on the item channel and results leave on the result channel,
// both valid/ready; a transfer happens when valid and ready are both high.
// cfg_write_en writes cfg_write_data as the mode (0 encode, 1 decode) and
// clears the group state; the user must see that it is written only while the
// block is idle, which the block itself does not enforce. Each accepted item
// is translated in one pass into up to four results that are loaded into a
// four-entry result buffer, so the first result is visible in the cycle after
// the transfer. The buffer drains one result per cycle while the receiver is
// ready. A new item is accepted when the buffer is empty or holds one result
// that is taken in the same cycle, so an item is not taken while earlier
// results still wait: encoding gives 1, 1 and 2 results for the bytes of a
// group and up to 4 for a final byte, and decoding at most one per character.
// A stalled receiver holds the buffer and blocks further items. Reset selects
// encode mode and empties both the group state and the buffer.
// ----------------------------------------------------------------------------
module base64_codec_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic              cfg_write_data,
    input  logic              item_valid,
    output logic              item_ready,
    input  b64c_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output b64c_pkg::result_t result
);

    logic              mode_reg;
    logic [1:0]        pos_reg;
    logic [5:0]        carry_reg;
    logic              pad_reg;
    logic [2:0]        cnt_reg;
    b64c_pkg::result_t res_reg [4];

    logic [1:0]        pos_next;
    logic [5:0]        carry_next;
    logic              pad_next;
    logic [2:0]        cnt_next;
    b64c_pkg::result_t res_next [4];

    logic              item_xfer;
    logic              result_xfer;

    assign result_valid = (cnt_reg != 3'd0);
    assign result       = res_reg[0];
    assign result_xfer  = result_valid && result_ready;
    assign item_ready   = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && result_ready);
    assign item_xfer    = item_valid && item_ready;

    always_comb
    begin
        logic [7:0] b;
        logic [6:0] val;
        logic       err;
        b          = item.in_byte;
        val        = b64c_pkg::value_of(b);
        err        = 1'b0;
        pos_next   = pos_reg;
        carry_next = carry_reg;
        pad_next   = pad_reg;
        cnt_next   = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            res_next[i].out_byte = 8'd0;
            res_next[i].out_kind = b64c_pkg::KIND_DATA;
            res_next[i].out_last = 1'b0;
        end

        if (!mode_reg)
        begin
            case (pos_reg)
                2'd0:
                begin
                    res_next[0].out_byte = b64c_pkg::char_of(b[7:2]);
                    carry_next           = {b[1:0], 4'b0000};
                    pos_next             = 2'd1;
                    cnt_next             = 3'd1;
                    if (item.in_last)
                    begin
                        res_next[1].out_byte = b64c_pkg::char_of(carry_next);
                        res_next[2].out_byte = b64c_pkg::PAD_CHAR;
                        res_next[3].out_byte = b64c_pkg::PAD_CHAR;
                        cnt_next             = 3'd4;
                    end
                end
                2'd1:
                begin
                    res_next[0].out_byte = b64c_pkg::char_of(carry_reg | {2'b00, b[7:4]});
                    carry_next           = {b[3:0], 2'b00};
                    pos_next             = 2'd2;
                    cnt_next             = 3'd1;
                    if (item.in_last)
                    begin
                        res_next[1].out_byte = b64c_pkg::char_of(carry_next);
                        res_next[2].out_byte = b64c_pkg::PAD_CHAR;
                        cnt_next             = 3'd3;
                    end
                end
                default:
                begin
                    res_next[0].out_byte = b64c_pkg::char_of(carry_reg | {4'b0000, b[7:6]});
                    res_next[1].out_byte = b64c_pkg::char_of(b[5:0]);
                    carry_next           = 6'd0;
                    pos_next             = 2'd0;
                    cnt_next             = 3'd2;
                end
            endcase
        end
        else
        begin
            if (b == b64c_pkg::PAD_CHAR)
            begin
                pad_next = 1'b1;
            end
            else if (val[6] || pad_reg)
            begin
                err = 1'b1;
            end
            else
            begin
                case (pos_reg)
                    2'd0:
                    begin
                        carry_next = val[5:0];
                        pos_next   = 2'd1;
                    end
                    2'd1:
                    begin
                        res_next[0].out_byte = {carry_reg, val[5:4]};
                        carry_next           = {2'b00, val[3:0]};
                        pos_next             = 2'd2;
                        cnt_next             = 3'd1;
                    end
                    2'd2:
                    begin
                        res_next[0].out_byte = {carry_reg[3:0], val[5:2]};
                        carry_next           = {4'b0000, val[1:0]};
                        pos_next             = 2'd3;
                        cnt_next             = 3'd1;
                    end
                    default:
                    begin
                        res_next[0].out_byte = {carry_reg[1:0], val[5:0]};
                        carry_next           = 6'd0;
                        pos_next             = 2'd0;
                        cnt_next             = 3'd1;
                    end
                endcase
            end

            if (err)
            begin
                res_next[0].out_kind = b64c_pkg::KIND_ERROR;
                cnt_next             = 3'd1;
            end

            // A message that ends on a lone character reports an error; one
            // that ends without any result reports an end marker.
            if (item.in_last)
            begin
                if (!err && pos_next == 2'd1)
                begin
                    res_next[0].out_kind = b64c_pkg::KIND_ERROR;
                    cnt_next             = 3'd1;
                end
                else if (cnt_next == 3'd0)
                begin
                    res_next[0].out_kind = b64c_pkg::KIND_END;
                    cnt_next             = 3'd1;
                end
            end
        end

        if (item.in_last)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (3'(i) + 3'd1 == cnt_next)
                begin
                    res_next[i].out_last = 1'b1;
                end
            end
            pos_next   = 2'd0;
            carry_next = 6'd0;
            pad_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            pos_reg   <= 2'd0;
            carry_reg <= 6'd0;
            pad_reg   <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            mode_reg  <= cfg_write_data;
            pos_reg   <= 2'd0;
            carry_reg <= 6'd0;
            pad_reg   <= 1'b0;
        end
        else if (item_xfer)
        begin
            pos_reg   <= pos_next;
            carry_reg <= carry_next;
            pad_reg   <= pad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else if (item_xfer)
        begin
            cnt_reg <= cnt_next;
        end
        else if (result_xfer)
        begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            for (int i = 0; i < 4; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
        else if (result_xfer)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res_reg[i] <= res_reg[i + 1];
            end
        end
    end

endmodule

// ===== design/b64c_checker.sv =====
// ----------------------------------------------------------------------------
// Base64 codec port checker
// Port-level assertions for the codec core, attached by bind.
// ----------------------------------------------------------------------------
`include "base64_codec_core_macros.svh"

module b64c_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_ready,
    input logic              result_valid,
    input logic              result_ready,
    input b64c_pkg::result_t result
);

    `B64C_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(result), "result changed while stalled")
    `B64C_ASSERT_IMP(a_stall_blocks_items, result_valid && !result_ready,
        !item_ready, "item taken while result is stalled")
    `B64C_ASSERT_IMP(a_error_zero_byte,
        result_valid && result.out_kind == b64c_pkg::KIND_ERROR,
        result.out_byte == 8'd0, "error result carries data")
    `B64C_ASSERT_IMP(a_end_is_last,
        result_valid && result.out_kind == b64c_pkg::KIND_END,
        result.out_last, "end marker not final")

endmodule

bind base64_codec_core b64c_checker u_b64c_checker (.*);

// ===== test/tb_base64_codec_core.sv =====
// ----------------------------------------------------------------------------
// Base64 codec core testbench
// Drives byte and character streams through the codec in both modes and
// checks every result against a built-in model or the table. A short table
// of directed items comes first, then random messages under three idle and
// stall settings, with mode writes between messages while the block is idle.
// ----------------------------------------------------------------------------
module tb_base64_codec_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 72;
    localparam int MAX_PRINTS     = 60;

    localparam logic [511:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic                    cfg_wr;
        logic                    cfg_val;
        logic [7:0]              in_byte;
        logic                    in_last;
        logic [2:0]              n_typed;
        b64c_pkg::result_t [0:3] typed;
    } stim_row_t;

    localparam b64c_pkg::result_t NO_R     = '0;
    localparam b64c_pkg::result_t ERR_LAST = '{8'h00, b64c_pkg::KIND_ERROR, 1'b1};
    localparam b64c_pkg::result_t ERR_MID  = '{8'h00, b64c_pkg::KIND_ERROR, 1'b0};
    localparam b64c_pkg::result_t END_LAST = '{8'h00, b64c_pkg::KIND_END, 1'b1};
    localparam b64c_pkg::result_t [0:3] NO_RES   = '0;
    localparam b64c_pkg::result_t [0:3] ERR_L4   = '{ERR_LAST, NO_R, NO_R, NO_R};
    localparam b64c_pkg::result_t [0:3] ERR_M4   = '{ERR_MID, NO_R, NO_R, NO_R};
    localparam b64c_pkg::result_t [0:3] END_L4   = '{END_LAST, NO_R, NO_R, NO_R};
    localparam b64c_pkg::result_t [0:3] ENC_ZERO = '{
        '{"A", b64c_pkg::KIND_DATA, 1'b0},
        '{"A", b64c_pkg::KIND_DATA, 1'b0},
        '{b64c_pkg::PAD_CHAR, b64c_pkg::KIND_DATA, 1'b0},
        '{b64c_pkg::PAD_CHAR, b64c_pkg::KIND_DATA, 1'b1}};
    localparam b64c_pkg::result_t [0:3] ENC_ONES = '{
        '{"/", b64c_pkg::KIND_DATA, 1'b0},
        '{"w", b64c_pkg::KIND_DATA, 1'b0},
        '{b64c_pkg::PAD_CHAR, b64c_pkg::KIND_DATA, 1'b0},
        '{b64c_pkg::PAD_CHAR, b64c_pkg::KIND_DATA, 1'b1}};

    localparam int DIR_ROWS = 25;
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        '{1'b0, 1'b0, 8'h00, 1'b1, 3'd4, ENC_ZERO},
        '{1'b0, 1'b0, 8'hff, 1'b1, 3'd4, ENC_ONES},
        '{1'b0, 1'b0, 8'hff, 1'b0, 3'd0, NO_RES},
        '{1'b0, 1'b0, 8'hff, 1'b0, 3'd0, NO_RES},
        '{1'b0, 1'b0, 8'hff, 1'b1, 3'd0, NO_RES},
        '{1'b0, 1'b0, "M",   1'b0, 3'd0, NO_RES},
        '{1'b0, 1'b0, "a",   1'b1, 3'd0, NO_RES},
        '{1'b1, 1'b1, "T",   1'b0, 3'd0, NO_RES},
        '{1'b0, 1'b0, "W",   1'b0, 3'd0, NO_RES},
        '{1'b0, 1'b0, "F",   1'b0, 3'd0, NO_RES},
        '{1'b0, 1'b0, "u",   1'b1, 3'd0, NO_RES},
        '{1'b0, 1'b0, "!",   1'b1, 3'd1, ERR_L4},
        '{1'b0, 1'b0, "A",   1'b1, 3'd1, ERR_L4},
        '{1'b0, 1'b0, "=",   1'b1, 3'd1, END_L4},
        '{1'b0, 1'b0, "Q",   1'b0, 3'd0, NO_RES},
        '{1'b0, 1'b0, "Q",   1'b0, 3'd0, NO_RES},
        '{1'b0, 1'b0, "=",   1'b0, 3'd0, NO_RES},
        '{1'b0, 1'b0, "A",   1'b1, 3'd1, ERR_L4},
        '{1'b0, 1'b0, 8'hff, 1'b0, 3'd1, ERR_M4},
        '{1'b0, 1'b0, 8'h00, 1'b0, 3'd1, ERR_M4},
        '{1'b0, 1'b0, "+",   1'b0, 3'd0, NO_RES},
        '{1'b0, 1'b0, "/",   1'b1, 3'd0, NO_RES},
        '{1'b0, 1'b0, "Q",   1'b0, 3'd0, NO_RES},
        '{1'b1, 1'b0, 8'h10, 1'b1, 3'd0, NO_RES},
        '{1'b1, 1'b1, "=",   1'b1, 3'd1, END_L4}
    };

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              cfg_write_en   = 1'b0;
    logic              cfg_write_data = 1'b0;
    logic              item_valid     = 1'b0;
    logic              item_ready;
    b64c_pkg::item_t   item           = '0;
    logic              result_valid;
    logic              result_ready   = 1'b0;
    b64c_pkg::result_t result;

    logic              model_mode;
    logic [1:0]        model_pos;
    logic [5:0]        model_carry;
    logic              model_pad;
    b64c_pkg::result_t step_results [4];

    b64c_pkg::result_t pending_results [$];
    b64c_pkg::result_t oldest;
    int                mismatches    = 0;
    int                send_idle_pct = 26;
    int                recv_idle_pct = 45;
    int                quiet_cycles  = 0;

    base64_codec_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result)
    );

    always #5ns clk = ~clk;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        return B64_ALPHABET[8 * (63 - int'(v)) +: 8];
    endfunction

    function automatic logic [6:0] b64_value(input logic [7:0] c);
        for (int i = 0; i < 64; i++)
        begin
            if (b64_char(6'(i)) == c)
            begin
                return 7'(i);
            end
        end
        return 7'd64;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTS)
        begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
        mismatches++;
    endtask

    task automatic clear_model();
        model_pos   = 2'd0;
        model_carry = 6'd0;
        model_pad   = 1'b0;
    endtask

    task automatic add_result(input logic [7:0] b, input b64c_pkg::kind_t k,
                              inout int n);
        step_results[n] = '{b, k, 1'b0};
        n++;
    endtask

    // Steps the codec model by one item and leaves its results in step_results.
    task automatic codec_predict(input b64c_pkg::item_t it, output int n);
        logic [7:0] b;
        logic [6:0] v;
        logic       err;
        b   = it.in_byte;
        n   = 0;
        err = 1'b0;
        if (!model_mode)
        begin
            case (model_pos)
                2'd0:
                begin
                    add_result(b64_char(b[7:2]), b64c_pkg::KIND_DATA, n);
                    model_carry = {b[1:0], 4'b0000};
                    model_pos   = 2'd1;
                    if (it.in_last)
                    begin
                        add_result(b64_char(model_carry), b64c_pkg::KIND_DATA, n);
                        add_result(b64c_pkg::PAD_CHAR, b64c_pkg::KIND_DATA, n);
                        add_result(b64c_pkg::PAD_CHAR, b64c_pkg::KIND_DATA, n);
                    end
                end
                2'd1:
                begin
                    add_result(b64_char(model_carry | {2'b00, b[7:4]}),
                               b64c_pkg::KIND_DATA, n);
                    model_carry = {b[3:0], 2'b00};
                    model_pos   = 2'd2;
                    if (it.in_last)
                    begin
                        add_result(b64_char(model_carry), b64c_pkg::KIND_DATA, n);
                        add_result(b64c_pkg::PAD_CHAR, b64c_pkg::KIND_DATA, n);
                    end
                end
                default:
                begin
                    add_result(b64_char(model_carry | {4'b0000, b[7:6]}),
                               b64c_pkg::KIND_DATA, n);
                    add_result(b64_char(b[5:0]), b64c_pkg::KIND_DATA, n);
                    model_carry = 6'd0;
                    model_pos   = 2'd0;
                end
            endcase
        end
        else
        begin
            v = b64_value(b);
            if (b == b64c_pkg::PAD_CHAR)
            begin
                model_pad = 1'b1;
            end
            else if (v[6] || model_pad)
            begin
                err = 1'b1;
            end
            else
            begin
                case (model_pos)
                    2'd0:
                    begin
                        model_carry = v[5:0];
                        model_pos   = 2'd1;
                    end
                    2'd1:
                    begin
                        add_result({model_carry, v[5:4]}, b64c_pkg::KIND_DATA, n);
                        model_carry = {2'b00, v[3:0]};
                        model_pos   = 2'd2;
                    end
                    2'd2:
                    begin
                        add_result({model_carry[3:0], v[5:2]}, b64c_pkg::KIND_DATA, n);
                        model_carry = {4'b0000, v[1:0]};
                        model_pos   = 2'd3;
                    end
                    default:
                    begin
                        add_result({model_carry[1:0], v[5:0]}, b64c_pkg::KIND_DATA, n);
                        model_carry = 6'd0;
                        model_pos   = 2'd0;
                    end
                endcase
            end
            if (err)
            begin
                add_result(8'h00, b64c_pkg::KIND_ERROR, n);
            end
            if (it.in_last)
            begin
                if (!err && model_pos == 2'd1)
                begin
                    add_result(8'h00, b64c_pkg::KIND_ERROR, n);
                end
                else if (n == 0)
                begin
                    add_result(8'h00, b64c_pkg::KIND_END, n);
                end
            end
        end
        if (it.in_last)
        begin
            step_results[n - 1].out_last = 1'b1;
            clear_model();
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The sender holds off until every result is in before the mode changes.
    task automatic write_mode(input logic m);
        item_valid <= 1'b0;
        wait_drained();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= m;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        model_mode = m;
        clear_model();
    endtask

    task automatic send_item(input b64c_pkg::item_t it, input int n_typed,
                             input b64c_pkg::result_t [0:3] typed);
        int n;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
        begin
            @(posedge clk);
        end
        while (!(item_valid && item_ready));
        codec_predict(it, n);
        if (n_typed > 0)
        begin
            for (int i = 0; i < n_typed; i++)
            begin
                pending_results.push_back(typed[i]);
            end
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                pending_results.push_back(step_results[i]);
            end
        end
    endtask

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", result));
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (result.out_byte !== oldest.out_byte)
                begin
                    report_mismatch($sformatf("out_byte %h, expected %h",
                                              result.out_byte, oldest.out_byte));
                end
                if (result.out_kind !== oldest.out_kind)
                begin
                    report_mismatch($sformatf("out_kind %0d, expected %0d",
                                              result.out_kind, oldest.out_kind));
                end
                if (result.out_last !== oldest.out_last)
                begin
                    report_mismatch($sformatf("out_last %b, expected %b",
                                              result.out_last, oldest.out_last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        b64c_pkg::item_t it;
        b64c_pkg::item_t msg_q [$];
        stim_row_t       row;
        logic            mode;
        logic            need_cfg;
        int              sent;
        int              len;
        int              pads;
        logic            noise;

        model_mode = 1'b0;
        clear_model();
        need_cfg = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = DIR_TABLE[r];
            if (row.cfg_wr)
            begin
                write_mode(row.cfg_val);
            end
            it.in_byte = row.in_byte;
            it.in_last = row.in_last;
            send_item(it, int'(row.n_typed), row.typed);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 26;
                    recv_idle_pct = 45;
                end
                1:
                begin
                    send_idle_pct = 45;
                    recv_idle_pct = 26;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                mode = 1'($urandom_range(1));
                if (mode != model_mode || need_cfg || $urandom_range(3) == 0)
                begin
                    write_mode(mode);
                end
                need_cfg = 1'b0;
                msg_q.delete();
                it.in_last = 1'b0;
                if (!mode)
                begin
                    len = $urandom_range(1, 9);
                    for (int i = 0; i < len; i++)
                    begin
                        it.in_byte = 8'($urandom);
                        msg_q.push_back(it);
                    end
                end
                else
                begin
                    noise = ($urandom_range(99) < 20);
                    len   = $urandom_range(1, 10);
                    for (int i = 0; i < len; i++)
                    begin
                        if (noise && $urandom_range(99) < 30)
                        begin
                            it.in_byte = 8'($urandom);
                        end
                        else
                        begin
                            it.in_byte = b64_char(6'($urandom_range(63)));
                        end
                        msg_q.push_back(it);
                    end
                    pads = ($urandom_range(1) == 1) ? $urandom_range(1, 3) : 0;
                    for (int i = 0; i < pads; i++)
                    begin
                        it.in_byte = b64c_pkg::PAD_CHAR;
                        msg_q.push_back(it);
                    end
                    if (pads > 0 && $urandom_range(99) < 15)
                    begin
                        it.in_byte = b64_char(6'($urandom_range(63)));
                        msg_q.push_back(it);
                    end
                end
                it = msg_q.pop_back();
                if ($urandom_range(99) < 8)
                begin
                    need_cfg = 1'b1;
                end
                else
                begin
                    it.in_last = 1'b1;
                end
                msg_q.push_back(it);
                foreach (msg_q[i])
                begin
                    send_item(msg_q[i], 0, NO_RES);
                end
                sent += msg_q.size();
            end
        end

        item_valid <= 1'b0;
        wait_drained();
        if (pending_results.size() != 0)
        begin
            report_mismatch("expected results never arrived");
        end
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
